@@ sv/cnin_pkg.sv @@
package cnin_pkg;

  // Field widths
  localparam int unsigned NodeW  = 12;
  localparam int unsigned CountW = 13;

  localparam logic [NodeW-1:0]  INDEX_MAX = 12'hFFF;
  localparam logic [CountW-1:0] COUNT_MAX = 13'd4096;
  localparam logic [CountW-1:0] COUNT_MIN = 13'd1;

  // Control states of the item sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RESOLVE
  } state_e;

  // One entry of the cut node table
  typedef struct packed {
    logic             valid;
    logic [NodeW-1:0] index;
  } assign_entry_t;

  // Table access requests from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_assign;
    logic wr_claim;
  } tbl_ctrl_t;

  // Clamp the configured count into its usable range
  function automatic logic [CountW-1:0] effective_count(input logic [CountW-1:0] count);
    logic [CountW-1:0] eff;
    if (count == '0) begin
      eff = COUNT_MIN;
    end else if (count > COUNT_MAX) begin
      eff = COUNT_MAX;
    end else begin
      eff = count;
    end
    return eff;
  endfunction

endpackage

@@ sv/cnin_if.sv @@
interface cnin_in_if;
  import cnin_pkg::*;

  logic             valid;
  logic             ready;
  logic [NodeW-1:0] cut_node;
  logic [NodeW-1:0] original_node;

  modport source (output valid, output cut_node, output original_node, input ready);
  modport sink (input valid, input cut_node, input original_node, output ready);
endinterface

interface cnin_out_if;
  import cnin_pkg::*;

  logic             valid;
  logic             ready;
  logic [NodeW-1:0] new_index;
  logic             index_overflow;

  modport source (output valid, output new_index, output index_overflow, input ready);
  modport sink (input valid, input new_index, input index_overflow, output ready);
endinterface

interface cnin_cfg_if;
  import cnin_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] original_node_count;

  modport source (output valid, output original_node_count, input ready);
  modport sink (input valid, input original_node_count, output ready);
endinterface

@@ sv/cnin_reduce.sv @@
module cnin_reduce #(
  parameter int unsigned CUT_NODES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [cnin_pkg::NodeW-1:0]   node_i,
  output logic                         valid_o,
  output logic [$clog2(CUT_NODES)-1:0] idx_o
);
  import cnin_pkg::*;

  localparam int unsigned CIW   = $clog2(CUT_NODES);
  localparam int unsigned RECIP = 4096 / CUT_NODES;

  logic v1_q, v2_q;

  // Advance the valid flags through both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;

  if (CUT_NODES < 4096) begin : g_mod
    localparam logic [NodeW-1:0] RECIP_L = NodeW'(RECIP);
    localparam logic [NodeW-1:0] CUT_L   = NodeW'(CUT_NODES);

    logic [NodeW-1:0]   x1_q;
    logic [NodeW-1:0]   q1_q;
    logic [CountW-1:0]  r2_q;
    logic [2*NodeW-1:0] prod;
    logic [2*NodeW-1:0] back;
    logic [CountW-1:0]  r_fix;

    // Estimate the quotient by a reciprocal; it is low by at most one
    assign prod = {{NodeW{1'b0}}, node_i} * {{NodeW{1'b0}}, RECIP_L};
    assign back = {{NodeW{1'b0}}, q1_q} * {{NodeW{1'b0}}, CUT_L};

    always_ff @(posedge clk_i) begin
      x1_q <= node_i;
      q1_q <= prod[2*NodeW-1:NodeW];
      r2_q <= {1'b0, x1_q} - back[CountW-1:0];
    end

    // Correct a remainder that is one divisor too large
    always_comb begin
      if (r2_q >= {1'b0, CUT_L}) begin
        r_fix = r2_q - {1'b0, CUT_L};
      end else begin
        r_fix = r2_q;
      end
    end

    assign idx_o = CIW'(r_fix);
  end else begin : g_pass
    logic [NodeW-1:0] x1_q, x2_q;

    always_ff @(posedge clk_i) begin
      x1_q <= node_i;
      x2_q <= x1_q;
    end

    assign idx_o = CIW'(x2_q);
  end

endmodule

@@ sv/cnin_tables.sv @@
module cnin_tables #(
  parameter int unsigned CUT_NODES  = 4096,
  parameter int unsigned ORIG_NODES = 4096
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  cnin_pkg::tbl_ctrl_t                                   ctrl_i,
  input  logic [$clog2(CUT_NODES)-1:0]                          cut_addr_i,
  input  logic [((ORIG_NODES > 1) ? $clog2(ORIG_NODES) : 1)-1:0] orig_addr_i,
  input  cnin_pkg::assign_entry_t                               assign_wdata_i,
  output cnin_pkg::assign_entry_t                               assign_rdata_o,
  output logic                                                  claim_rdata_o,
  output logic                                                  busy_o
);
  import cnin_pkg::*;

  localparam int unsigned CIW  = $clog2(CUT_NODES);
  localparam int unsigned OIW  = (ORIG_NODES > 1) ? $clog2(ORIG_NODES) : 1;
  localparam int unsigned MAXD = (CUT_NODES > ORIG_NODES) ? CUT_NODES : ORIG_NODES;
  localparam int unsigned CLW  = $clog2(MAXD);
  localparam logic [CLW-1:0] CLR_LAST = CLW'(MAXD - 1);
  localparam logic [CLW:0]   CUT_END  = (CLW+1)'(CUT_NODES);
  localparam logic [CLW:0]   ORIG_END = (CLW+1)'(ORIG_NODES);

  assign_entry_t assign_mem [CUT_NODES];
  logic          claim_mem  [ORIG_NODES];

  logic          busy_q;
  logic [CLW-1:0] clr_q;
  logic          clr_cut, clr_orig;
  assign_entry_t assign_rd_q;
  logic          claim_rd_q;

  assign clr_cut  = {1'b0, clr_q} < CUT_END;
  assign clr_orig = {1'b0, clr_q} < ORIG_END;

  // Sweep both tables once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == CLR_LAST) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Write either the clearing sweep or the sequencer's updates
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (clr_cut) begin
        assign_mem[clr_q[CIW-1:0]] <= '0;
      end
      if (clr_orig) begin
        claim_mem[clr_q[OIW-1:0]] <= 1'b0;
      end
    end else begin
      if (ctrl_i.wr_assign) begin
        assign_mem[cut_addr_i] <= assign_wdata_i;
      end
      if (ctrl_i.wr_claim) begin
        claim_mem[orig_addr_i] <= 1'b1;
      end
    end
  end

  // Registered reads of both tables
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      assign_rd_q <= assign_mem[cut_addr_i];
      claim_rd_q  <= claim_mem[orig_addr_i];
    end
  end

  assign assign_rdata_o = assign_rd_q;
  assign claim_rdata_o  = claim_rd_q;
  assign busy_o         = busy_q;

endmodule

@@ sv/cut_node_index_normalizer_top.sv @@
// Renumbers cut-mesh nodes. Each transaction carries a cut node and its
// original node; the first sighting of a cut node takes the original index if
// it is below both the configured original node count and ORIG_NODES and no
// cut node has claimed it yet, otherwise the next spare index counting up from
// the configured original node count, and later sightings return the stored
// index. When spare indices are used up the result is 4095 with index_overflow
// set. One item is in flight at a time: it passes through cut index reduction,
// a registered table read and a read-modify-write step that waits for a free
// output register, and only then is the next item accepted. A finished result
// waits in the output register while the next item is taken. After reset the
// tables are cleared by a sweep, during which no item is accepted; configuration
// writes are taken at any time but belong between items, and a write also restarts spare indices.
module cut_node_index_normalizer_top #(
  parameter int unsigned CUT_NODES  = 4096,
  parameter int unsigned ORIG_NODES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cnin_cfg_if.sink     cfg_i,
  cnin_in_if.sink      item_i,
  cnin_out_if.source   result_o
);
  import cnin_pkg::*;

  localparam int unsigned CIW = $clog2(CUT_NODES);
  localparam int unsigned OIW = (ORIG_NODES > 1) ? $clog2(ORIG_NODES) : 1;

  state_e            state_q, state_d;
  logic [CountW-1:0] eff_q;
  logic [CountW-1:0] spare_q;
  logic [NodeW-1:0]  orig_q;
  logic [CIW-1:0]    cut_q;
  logic              out_v_q;
  logic [NodeW-1:0]  out_idx_q;
  logic              out_ovf_q;

  logic              in_acc, cfg_acc, out_free, load;
  logic              red_valid;
  logic [CIW-1:0]    red_idx;
  tbl_ctrl_t         ctrl;
  logic [CIW-1:0]    cut_addr;
  assign_entry_t     assign_rd, assign_wr;
  logic              claim_rd, tbl_busy;
  logic              usable, take_spare;
  logic [NodeW-1:0]  res_idx;
  logic              res_ovf;

  assign in_acc       = item_i.valid && item_i.ready;
  assign cfg_acc      = cfg_i.valid && cfg_i.ready;
  assign item_i.ready = (state_q == ST_IDLE) && !tbl_busy;
  assign cfg_i.ready  = 1'b1;
  assign out_free     = !out_v_q || result_o.ready;

  cnin_reduce #(
    .CUT_NODES (CUT_NODES)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_acc),
    .node_i  (item_i.cut_node),
    .valid_o (red_valid),
    .idx_o   (red_idx)
  );

  assign cut_addr = (state_q == ST_RESOLVE) ? cut_q : red_idx;

  cnin_tables #(
    .CUT_NODES  (CUT_NODES),
    .ORIG_NODES (ORIG_NODES)
  ) u_tables (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cut_addr_i     (cut_addr),
    .orig_addr_i    (OIW'(orig_q)),
    .assign_wdata_i (assign_wr),
    .assign_rdata_o (assign_rd),
    .claim_rdata_o  (claim_rd),
    .busy_o         (tbl_busy)
  );

  // Decide the index of the current cut node
  always_comb begin
    usable     = ({1'b0, orig_q} < eff_q) && ({20'd0, orig_q} < 32'(ORIG_NODES));
    take_spare = 1'b0;
    res_ovf    = 1'b0;
    if (assign_rd.valid) begin
      res_idx = assign_rd.index;
    end else if (usable && !claim_rd) begin
      res_idx = orig_q;
    end else if (!spare_q[CountW-1]) begin
      res_idx    = spare_q[NodeW-1:0];
      take_spare = 1'b1;
    end else begin
      res_idx = INDEX_MAX;
      res_ovf = 1'b1;
    end
    assign_wr.valid = 1'b1;
    assign_wr.index = res_idx;
  end

  // Sequence one item through reduction, read and write-back
  always_comb begin
    state_d        = state_q;
    ctrl.rd_en     = 1'b0;
    ctrl.wr_assign = 1'b0;
    ctrl.wr_claim  = 1'b0;
    load           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_valid) begin
          ctrl.rd_en = 1'b1;
          state_d    = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          load           = 1'b1;
          ctrl.wr_assign = !assign_rd.valid && !res_ovf;
          ctrl.wr_claim  = !assign_rd.valid && !take_spare && !res_ovf;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the count register and the spare index counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q   <= COUNT_MAX;
      spare_q <= COUNT_MAX;
    end else if (cfg_acc) begin
      eff_q   <= effective_count(cfg_i.original_node_count);
      spare_q <= effective_count(cfg_i.original_node_count);
    end else if (load && take_spare) begin
      spare_q <= spare_q + 1'b1;
    end
  end

  // Capture the item fields and the reduced cut index
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      orig_q <= item_i.original_node;
    end
    if (red_valid) begin
      cut_q <= red_idx;
    end
  end

  // Output register: drop on transaction, load on completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= 1'b1;
    end else if (result_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q <= res_idx;
      out_ovf_q <= res_ovf;
    end
  end

  assign result_o.valid          = out_v_q;
  assign result_o.new_index      = out_idx_q;
  assign result_o.index_overflow = out_ovf_q;

endmodule

@@ dv/tb_cut_node_index_normalizer_top.sv @@
`timescale 1ns / 1ps

module tb_cut_node_index_normalizer_top;
  import cnin_pkg::*;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned PhaseItems = 85;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned DrainWait  = 8;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One directed row: an item or a count write, with an optional typed result
  typedef struct {
    row_kind_e         kind;
    logic [CountW-1:0] count;
    logic [NodeW-1:0]  cut;
    logic [NodeW-1:0]  orig;
    bit                typed;
    logic [NodeW-1:0]  idx;
    logic              ovf;
  } dir_row_t;

  typedef struct packed {
    logic [NodeW-1:0] idx;
    logic             ovf;
  } renum_t;

  logic clk_i;
  logic rst_ni;

  cnin_cfg_if cfg_if ();
  cnin_in_if  item_if ();
  cnin_out_if res_if ();

  cut_node_index_normalizer_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (res_if)
  );

  // Shadow copy of the renumbering tables
  bit               node_known   [TableDepth];
  logic [NodeW-1:0] node_idx     [TableDepth];
  bit               orig_claimed [TableDepth];
  logic [CountW-1:0] node_count;
  logic [CountW-1:0] spare_next;

  renum_t expected_idx_q[$];
  int     recent_cuts[$];

  int  errors      = 0;
  int  n_items     = 0;
  int  n_results   = 0;
  int  n_overflows = 0;
  int  n_reused    = 0;
  int  n_cfg       = 0;
  bit  steady      = 0;
  int  stall_left  = 0;
  int  idle_cycles = 0;

  dir_row_t dir_rows [20] = '{
    '{ROW_ITEM, 13'd0,    12'd0,     12'd0,     1'b1, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd0,     12'd5,     1'b1, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd1,     12'd0,     1'b1, 12'd4095,  1'b1},
    '{ROW_ITEM, 13'd0,    12'd1,     12'd1,     1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd4095,  12'd4095,  1'b1, 12'd4095,  1'b0},
    '{ROW_ITEM, 13'd0,    12'd4094,  12'd4095,  1'b1, 12'd4095,  1'b1},
    '{ROW_CFG,  13'd0,    12'd0,     12'd0,     1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd2,     12'd0,     1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd3,     12'd2,     1'b0, 12'd0,     1'b0},
    '{ROW_CFG,  13'd8191, 12'd0,     12'd0,     1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd5,     12'd4094,  1'b1, 12'd4094,  1'b0},
    '{ROW_ITEM, 13'd0,    12'd6,     12'd4094,  1'b1, 12'd4095,  1'b1},
    '{ROW_CFG,  13'd4095, 12'd0,     12'd0,     1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd7,     12'd4095,  1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd8,     12'd100,   1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'd9,     12'd4095,  1'b1, 12'd4095,  1'b1},
    '{ROW_ITEM, 13'd0,    12'd7,     12'd0,     1'b0, 12'd0,     1'b0},
    '{ROW_CFG,  13'd4096, 12'd0,     12'd0,     1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'hAAA,   12'h555,   1'b0, 12'd0,     1'b0},
    '{ROW_ITEM, 13'd0,    12'h555,   12'hAAA,   1'b0, 12'd0,     1'b0}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamp the programmed count into 1..4096
  function automatic logic [CountW-1:0] usable_count(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] res;
    res = cnt;
    if (cnt == '0) begin
      res = 13'd1;
    end else if (cnt > 13'd4096) begin
      res = 13'd4096;
    end
    return res;
  endfunction

  // Renumber one cut node and update the shadow tables
  function automatic renum_t renumber_node(input logic [NodeW-1:0] cut,
                                           input logic [NodeW-1:0] orig);
    renum_t res;
    res.ovf = 1'b0;
    if (node_known[cut]) begin
      res.idx = node_idx[cut];
    end else if ({1'b0, orig} < usable_count(node_count) && !orig_claimed[orig]) begin
      orig_claimed[orig] = 1'b1;
      res.idx = orig;
      node_idx[cut] = orig;
      node_known[cut] = 1'b1;
    end else if (spare_next <= {1'b0, INDEX_MAX}) begin
      res.idx = spare_next[NodeW-1:0];
      spare_next = spare_next + 13'd1;
      node_idx[cut] = res.idx;
      node_known[cut] = 1'b1;
    end else begin
      res.idx = INDEX_MAX;
      res.ovf = 1'b1;
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones, none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, wait for the transaction, record the expected result
  task automatic push_node(input logic [NodeW-1:0] cut, input logic [NodeW-1:0] orig,
                           input bit typed, input renum_t typed_res);
    renum_t pred;
    int     gap;
    item_if.valid         <= 1'b1;
    item_if.cut_node      <= cut;
    item_if.original_node <= orig;
    do begin
      @(posedge clk_i);
    end while (!item_if.ready);
    pred = renumber_node(cut, orig);
    expected_idx_q.push_back(typed ? typed_res : pred);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain outstanding results, then write the original node count
  task automatic load_node_count(input logic [CountW-1:0] cnt);
    item_if.valid <= 1'b0;
    while (expected_idx_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_if.valid               <= 1'b1;
    cfg_if.original_node_count <= cnt;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    node_count = cnt;
    spare_next = usable_count(cnt);
    n_cfg++;
  endtask

  // Result side: check each transaction, stall at random
  initial begin
    renum_t exp_res;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (expected_idx_q.size() == 0) begin
          $display("%0t: unexpected result idx=%0d ovf=%0b", $time,
                   res_if.new_index, res_if.index_overflow);
          errors++;
        end else begin
          exp_res = expected_idx_q.pop_front();
          if (res_if.new_index !== exp_res.idx) begin
            $display("%0t: new_index expected %0d actual %0d", $time,
                     exp_res.idx, res_if.new_index);
            errors++;
          end
          if (res_if.index_overflow !== exp_res.ovf) begin
            $display("%0t: index_overflow expected %0b actual %0b", $time,
                     exp_res.ovf, res_if.index_overflow);
            errors++;
          end
          if (exp_res.ovf) n_overflows++;
        end
      end
      if (steady) begin
        stall_left = 0;
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    renum_t typed_res;
    renum_t none;
    logic [NodeW-1:0] cut;
    logic [NodeW-1:0] orig;
    logic [CountW-1:0] cnt;
    int eff;
    int lo;
    int hi;
    int r;
    int base;

    none = '0;
    rst_ni                     <= 1'b0;
    item_if.valid              <= 1'b0;
    item_if.cut_node           <= '0;
    item_if.original_node      <= '0;
    cfg_if.valid               <= 1'b0;
    cfg_if.original_node_count <= '0;
    for (int i = 0; i < TableDepth; i++) begin
      node_known[i]   = 1'b0;
      node_idx[i]     = '0;
      orig_claimed[i] = 1'b0;
    end
    node_count = COUNT_MAX;
    spare_next = usable_count(COUNT_MAX);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: extremes, claims, spares, clamping, exhaustion
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        load_node_count(dir_rows[i].count);
      end else begin
        typed_res.idx = dir_rows[i].idx;
        typed_res.ovf = dir_rows[i].ovf;
        push_node(dir_rows[i].cut, dir_rows[i].orig, dir_rows[i].typed, typed_res);
      end
    end

    // Random phases, each under its own count
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: cnt = CountW'($urandom_range(1, 32));
        1: cnt = 13'd4096;
        2: cnt = CountW'($urandom_range(4085, 4095));
        3: cnt = CountW'($urandom_range(0, 8191));
        4: cnt = CountW'($urandom_range(4097, 8191));
        default: cnt = CountW'($urandom_range(1000, 3000));
      endcase
      load_node_count(cnt);
      steady = (ph == 1) || ($urandom_range(0, 3) == 0);
      eff = int'(usable_count(cnt));
      base = $urandom_range(0, TableDepth - 64);
      for (int k = 0; k < PhaseItems; k++) begin
        // Pick the cut node: revisit, a dense window, or anywhere
        r = $urandom_range(0, 99);
        if (r < 35 && recent_cuts.size() != 0) begin
          cut = NodeW'(recent_cuts[$urandom_range(0, recent_cuts.size() - 1)]);
          n_reused++;
        end else if (r < 55) begin
          cut = NodeW'(base + $urandom_range(0, 63));
        end else begin
          cut = NodeW'($urandom_range(0, TableDepth - 1));
        end
        recent_cuts.push_back(int'(cut));
        if (recent_cuts.size() > 64) void'(recent_cuts.pop_front());
        // Pick the original node: in range, at the count boundary, or anywhere
        r = $urandom_range(0, 99);
        if (r < 50) begin
          hi = (eff + 3 > TableDepth - 1) ? TableDepth - 1 : eff + 3;
          orig = NodeW'($urandom_range(0, hi));
        end else if (r < 70) begin
          lo = (eff < 2) ? 0 : eff - 2;
          hi = (eff + 1 > TableDepth - 1) ? TableDepth - 1 : eff + 1;
          orig = NodeW'($urandom_range(lo, hi));
        end else begin
          orig = NodeW'($urandom_range(0, TableDepth - 1));
        end
        push_node(cut, orig, 1'b0, none);
        if (k == PhaseItems / 2) steady = !steady;
      end
    end

    // Drain and finish
    item_if.valid <= 1'b0;
    steady = 0;
    while (expected_idx_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait * 2) @(posedge clk_i);
    $display("Ran %0d items (%0d revisits) over %0d count writes and %0d phases;",
             n_items, n_reused, n_cfg, NumPhases);
    $display("received %0d results, %0d of them flagged as out of spare indices.",
             n_results, n_overflows);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
